/* rtl/abs_pkg.sv */
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and constants for the arcade button sequencer: the sample,
// result and configuration layouts and the configuration register indexes.
// ----------------------------------------------------------------------------
package abs_pkg;

	localparam int unsigned IN_BYTES  = 5;
	localparam int unsigned OUT_BYTES = 2;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_SINGLE_MACHINE = 3'd0;
	localparam logic [IDX_W-1:0] REG_COIN_PULSE     = 3'd1;
	localparam logic [IDX_W-1:0] REG_START_DELAY    = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_PULSE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_RESET_HOLD     = 3'd4;
	localparam logic [IDX_W-1:0] REG_EVENT_ENABLES  = 3'd5;

	localparam logic [15:0] COIN_PULSE_RST  = 16'd100;
	localparam logic [15:0] START_DELAY_RST = 16'd500;
	localparam logic [15:0] START_PULSE_RST = 16'd100;
	localparam logic [15:0] RESET_HOLD_RST  = 16'd3000;
	localparam logic [2:0]  EVENT_EN_RST    = 3'd7;

	localparam int unsigned EN_VOLUME  = 0;
	localparam int unsigned EN_MRESET  = 1;
	localparam int unsigned EN_ATTRACT = 2;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        extra_button;
		logic        fire_button;
		logic        joy_down;
		logic        joy_up;
		logic        joy_right;
		logic        joy_left;
	} sample_t;

	typedef struct packed {
		logic       demo_sounds_off;
		logic       machine_reset;
		logic       attract_reset;
		logic       volume_down;
		logic       volume_up;
		logic       volume_request;
		logic       coin_out;
		logic       start_out;
		logic       fire_out;
		logic [3:0] joy_out;
	} result_t;

	typedef struct packed {
		logic        single_machine;
		logic [15:0] coin_pulse_ms;
		logic [15:0] start_delay_ms;
		logic [15:0] start_pulse_ms;
		logic [15:0] reset_hold_ms;
		logic [2:0]  event_enables;
	} cfg_t;

	localparam int unsigned SAMPLE_W = $bits(sample_t);
	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

/* rtl/abs_engine.sv */
// ----------------------------------------------------------------------------
// abs_engine
// Per-sample state update: coin/start sequence, volume requests, attract and
// machine reset events, and fire lockout. State advances when step is high.
// ----------------------------------------------------------------------------
module abs_engine #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  abs_pkg::sample_t smp,
	input  abs_pkg::cfg_t    cfg,
	output abs_pkg::result_t res
);
	import abs_pkg::*;

	localparam int unsigned NOW_W = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int unsigned CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

	localparam logic [2:0] SEQ_IDLE  = 3'd0;
	localparam logic [2:0] SEQ_COIN  = 3'd1;
	localparam logic [2:0] SEQ_WAIT  = 3'd2;
	localparam logic [2:0] SEQ_START = 3'd3;
	localparam logic [2:0] SEQ_HOLD  = 3'd4;

	logic [2:0]           seq_q, seq_d;
	logic [TIME_BITS-1:0] coin_stamp_q, coin_stamp_d;
	logic [TIME_BITS-1:0] hold_stamp_q, hold_stamp_d;
	logic                 hold_armed_q, hold_armed_d;
	logic [2:0]           prev_q, prev_d;
	logic                 lockout_q, lockout_d;
	logic                 first_seen_q;
	logic                 demo_off_q, demo_off_d;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] coin_diff, hold_diff, hold_base;
	logic [15:0]          seq_limit;
	logic                 coin_exp, hold_exp;

	assign now = TIME_BITS'(smp.now_ms[NOW_W-1:0]);

	always_comb begin
		case (seq_q)
			SEQ_COIN:  seq_limit = cfg.coin_pulse_ms;
			SEQ_WAIT:  seq_limit = cfg.start_delay_ms;
			default:   seq_limit = cfg.start_pulse_ms;
		endcase
	end

	assign coin_diff = now - coin_stamp_q;
	assign coin_exp  = CMP_W'(coin_diff) > CMP_W'(seq_limit);

	always_comb begin
		logic vol;
		logic edge_seen;
		logic armed_v;
		vol       = smp.extra_button & cfg.event_enables[EN_VOLUME];
		armed_v   = hold_armed_q & ~(vol & (smp.joy_up | smp.joy_down));
		hold_base = armed_v ? hold_stamp_q : now;
		hold_diff = now - hold_base;
		hold_exp  = CMP_W'(hold_diff) > CMP_W'(cfg.reset_hold_ms);

		lockout_d  = lockout_q;
		demo_off_d = demo_off_q;
		if (!first_seen_q && smp.fire_button) begin
			lockout_d  = 1'b1;
			demo_off_d = 1'b1;
		end

		seq_d        = seq_q;
		coin_stamp_d = coin_stamp_q;
		case (seq_q)
			SEQ_IDLE: begin
				if (smp.extra_button) begin
					seq_d        = SEQ_COIN;
					coin_stamp_d = now;
				end
			end
			SEQ_COIN, SEQ_WAIT, SEQ_START: begin
				if (coin_exp) begin
					seq_d        = seq_q + 3'd1;
					coin_stamp_d = now;
				end
			end
			SEQ_HOLD: begin
				if (!smp.extra_button)
					seq_d = SEQ_IDLE;
			end
			default: seq_d = SEQ_IDLE;
		endcase

		res                 = '0;
		res.volume_request  = vol;
		res.volume_up       = vol & smp.joy_up;
		res.volume_down     = vol & smp.joy_down;

		hold_armed_d = armed_v;
		hold_stamp_d = hold_stamp_q;
		prev_d       = prev_q;
		if (!cfg.single_machine) begin
			edge_seen = (smp.joy_up & ~prev_q[0]) | (smp.joy_down & ~prev_q[1])
				| (smp.extra_button & ~prev_q[2]);
			res.attract_reset = edge_seen & cfg.event_enables[EN_ATTRACT];
			if (smp.extra_button) begin
				hold_armed_d = 1'b1;
				hold_stamp_d = hold_base;
				if (hold_exp) begin
					hold_stamp_d      = now;
					res.machine_reset = cfg.event_enables[EN_MRESET];
				end
			end else begin
				hold_armed_d = 1'b0;
			end
			prev_d = {smp.extra_button, smp.joy_down, smp.joy_up};
		end else begin
			edge_seen = 1'b0;
		end

		res.joy_out  = {smp.joy_down, smp.joy_up, smp.joy_right, smp.joy_left};
		res.fire_out = smp.fire_button;
		if (lockout_d && smp.fire_button) begin
			res.joy_out  = '0;
			res.fire_out = 1'b0;
		end else begin
			lockout_d = 1'b0;
		end

		res.start_out       = seq_d inside {SEQ_START, SEQ_HOLD};
		res.coin_out        = (seq_d == SEQ_COIN);
		res.demo_sounds_off = demo_off_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SEQ_IDLE;
			coin_stamp_q <= '0;
			hold_stamp_q <= '0;
			hold_armed_q <= 1'b0;
			prev_q       <= '0;
			lockout_q    <= 1'b0;
			first_seen_q <= 1'b0;
			demo_off_q   <= 1'b0;
		end else if (step) begin
			seq_q        <= seq_d;
			coin_stamp_q <= coin_stamp_d;
			hold_stamp_q <= hold_stamp_d;
			hold_armed_q <= hold_armed_d;
			prev_q       <= prev_d;
			lockout_q    <= lockout_d;
			first_seen_q <= 1'b1;
			demo_off_q   <= demo_off_d;
		end
	end

endmodule

/* rtl/arcade_button_sequencer.sv */
// ----------------------------------------------------------------------------
// arcade_button_sequencer
// Button sampling front end with timed coin/start sequence, volume, attract
// and machine reset events, and fire lockout.
// ----------------------------------------------------------------------------
// One result beat per sample beat. A sample is held in an input register and
// its result in an output register, so a result is presented once its sample
// has been taken into the input register and the engine's result into the
// output register; a new sample is taken in every cycle while the output side
// keeps up: the single state update per sample in the engine sets that rate of
// one beat per cycle. Configuration writes take effect on the next clock edge
// and are meant to be made while no beat is in flight.
// ----------------------------------------------------------------------------
module arcade_button_sequencer #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// joy_left, joy_right, joy_up, joy_down, fire_button, extra_button, now_ms
	input  logic [abs_pkg::IN_BYTES*8-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// joy_out, fire_out, start_out, coin_out, volume_request, volume_up,
	// volume_down, attract_reset, machine_reset, demo_sounds_off
	output logic [abs_pkg::OUT_BYTES*8-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [abs_pkg::IDX_W-1:0]       cfg_index,
	input  logic [abs_pkg::CFG_W-1:0]       cfg_data
);
	import abs_pkg::*;

	cfg_t    cfg_q;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res;
	logic    m_valid_q;
	result_t m_res_q;
	logic    adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_machine <= 1'b0;
			cfg_q.coin_pulse_ms  <= COIN_PULSE_RST;
			cfg_q.start_delay_ms <= START_DELAY_RST;
			cfg_q.start_pulse_ms <= START_PULSE_RST;
			cfg_q.reset_hold_ms  <= RESET_HOLD_RST;
			cfg_q.event_enables  <= EVENT_EN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SINGLE_MACHINE: cfg_q.single_machine <= cfg_data[0];
				REG_COIN_PULSE:     cfg_q.coin_pulse_ms  <= cfg_data;
				REG_START_DELAY:    cfg_q.start_delay_ms <= cfg_data;
				REG_START_PULSE:    cfg_q.start_pulse_ms <= cfg_data;
				REG_RESET_HOLD:     cfg_q.reset_hold_ms  <= cfg_data;
				REG_EVENT_ENABLES:  cfg_q.event_enables  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			smp_s1 <= sample_t'(s_tdata[SAMPLE_W-1:0]);
		if (valid_s1 && adv)
			m_res_q <= res;
	end

	abs_engine #(
		.TIME_BITS(TIME_BITS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (valid_s1 && adv),
		.smp   (smp_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = (OUT_BYTES*8)'(m_res_q);

endmodule

/* rtl/abs_checker.sv */
// ----------------------------------------------------------------------------
// abs_checker
// Port-level checks for the arcade button sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module abs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_coin_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
		else $error("coin and start asserted together");

	a_vol: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[8] || m_tdata[9]) |-> m_tdata[7])
		else $error("volume step without volume request");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid && !m_tready)
		else $error("sample beat stalled while output side is free");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:13] == 3'b000)
		else $error("result padding not zero");

endmodule

bind arcade_button_sequencer abs_checker u_abs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
